@@ src/tmruart_pkg.sv @@
// Shared constants and status types for the bit-period timed 8N1 UART.
`timescale 1ns / 1ps

package tmruart_pkg;

    localparam int DATA_BITS   = 8;
    localparam int FRAME_BITS  = DATA_BITS + 2;
    localparam int COUNT_WIDTH = 16;
    localparam int RX_CNT_W    = COUNT_WIDTH + 1;
    localparam int BITS_W      = $clog2(FRAME_BITS + 1);

    localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = COUNT_WIDTH'(104);

    typedef logic [COUNT_WIDTH-1:0] period_t;

    typedef struct packed {
        logic tx_line;
        logic tx_busy;
        logic tx_done;
    } tx_status_t;

    typedef struct packed {
        logic                 rx_valid;
        logic [DATA_BITS-1:0] rx_byte;
    } rx_status_t;

endpackage

@@ src/tmruart_tx.sv @@
// Transmitter: frame shift register, bit counter and bit-period tick counter.
`timescale 1ns / 1ps

module tmruart_tx (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic                                  tx_start,
    input  logic [tmruart_pkg::DATA_BITS-1:0]     tx_byte,
    input  tmruart_pkg::period_t                  period,
    output tmruart_pkg::tx_status_t               status
);

    logic [tmruart_pkg::FRAME_BITS-1:0]  shift_reg, shift_next;
    logic [tmruart_pkg::BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [tmruart_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic                                active_reg, active_next;
    logic                                level_reg, level_next;
    logic                                done;
    logic [tmruart_pkg::COUNT_WIDTH-1:0] count_inc;

    assign count_inc = count_reg + 1'b1;

    always_comb begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        level_next     = level_reg;
        done           = 1'b0;
        if (!active_reg) begin
            if (tx_start) begin
                shift_next     = {1'b1, tx_byte, 1'b0};
                bits_left_next = tmruart_pkg::BITS_W'(tmruart_pkg::FRAME_BITS);
                count_next     = '0;
                active_next    = 1'b1;
            end
        end else begin
            count_next = count_inc;
            if (count_inc >= period) begin
                count_next = '0;
                if (bits_left_reg == '0) begin
                    active_next = 1'b0;
                    done        = 1'b1;
                end else begin
                    level_next     = shift_reg[0];
                    shift_next     = shift_reg >> 1;
                    bits_left_next = bits_left_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            level_reg     <= 1'b1;
        end else if (step) begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            level_reg     <= level_next;
        end
    end

    // Status reflects the state after this tick.
    assign status.tx_line = level_next;
    assign status.tx_busy = active_next;
    assign status.tx_done = done;

endmodule

@@ src/tmruart_rx.sv @@
// Receiver: start-edge hunt, bit-period sampling and byte assembly.
`timescale 1ns / 1ps

module tmruart_rx (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic                     rx_line,
    input  tmruart_pkg::period_t     period,
    output tmruart_pkg::rx_status_t  status
);

    logic [tmruart_pkg::DATA_BITS-1:0] shift_reg, shift_next;
    logic [tmruart_pkg::BITS_W-1:0]    bits_left_reg, bits_left_next;
    logic [tmruart_pkg::RX_CNT_W-1:0]  count_reg, count_next;
    logic                              hunting_reg, hunting_next;
    logic                              prev_reg;
    logic [tmruart_pkg::DATA_BITS-1:0] out_reg, out_next;
    logic                              valid;
    logic [tmruart_pkg::RX_CNT_W-1:0]  count_inc;
    logic [tmruart_pkg::RX_CNT_W-1:0]  target;
    logic [tmruart_pkg::BITS_W-1:0]    bits_dec;
    logic [tmruart_pkg::DATA_BITS-1:0] shift_in;

    assign count_inc = count_reg + 1'b1;
    assign shift_in  = {rx_line, shift_reg[tmruart_pkg::DATA_BITS-1:1]};

    // The first sample lands in the middle of bit zero, one and a half periods in.
    always_comb begin
        if (bits_left_reg >= tmruart_pkg::BITS_W'(tmruart_pkg::DATA_BITS)) begin
            target = {1'b0, period} + {2'b00, period[tmruart_pkg::COUNT_WIDTH-1:1]};
        end else begin
            target = {1'b0, period};
        end
    end

    always_comb begin
        bits_dec = (bits_left_reg != '0) ? bits_left_reg - 1'b1 : bits_left_reg;
    end

    always_comb begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        count_next     = count_reg;
        hunting_next   = hunting_reg;
        out_next       = out_reg;
        valid          = 1'b0;
        if (hunting_reg) begin
            if (prev_reg && !rx_line) begin
                hunting_next   = 1'b0;
                count_next     = '0;
                bits_left_next = tmruart_pkg::BITS_W'(tmruart_pkg::DATA_BITS);
                shift_next     = '0;
            end
        end else begin
            count_next = count_inc;
            if (count_inc >= target) begin
                count_next     = '0;
                shift_next     = shift_in;
                bits_left_next = bits_dec;
                if (bits_dec == '0) begin
                    out_next       = shift_in;
                    valid          = 1'b1;
                    bits_left_next = tmruart_pkg::BITS_W'(tmruart_pkg::DATA_BITS);
                    hunting_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            bits_left_reg <= tmruart_pkg::BITS_W'(tmruart_pkg::DATA_BITS);
            count_reg     <= '0;
            hunting_reg   <= 1'b1;
            prev_reg      <= 1'b1;
            out_reg       <= '0;
        end else if (step) begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
            hunting_reg   <= hunting_next;
            prev_reg      <= rx_line;
            out_reg       <= out_next;
        end
    end

    assign status.rx_valid = valid;
    assign status.rx_byte  = out_next;

endmodule

@@ src/timer_uart_8n1_full_duplex.sv @@
// Top level of the full-duplex 8N1 UART: input register, UART cores, result register.
`timescale 1ns / 1ps

// Each transfer on the s_ channel is one tick of UART time and yields exactly one
// transfer on the m_ channel, via the input register and then the result register.
// A new tick is taken every cycle unless the m_ side stalls: one input register
// feeds the transmit and receive cores, whose state update writes one result
// register. bit_period (cfg_wr_data) gives clock ticks per UART bit, with 0
// treated as 1; write it only while no tick is in flight.
module timer_uart_8n1_full_duplex (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tmruart_pkg::COUNT_WIDTH-1:0] cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_rx_line,
    input  logic                                s_tx_start,
    input  logic [tmruart_pkg::DATA_BITS-1:0]   s_tx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_tx_line,
    output logic                                m_tx_busy,
    output logic                                m_tx_done,
    output logic                                m_rx_valid,
    output logic [tmruart_pkg::DATA_BITS-1:0]   m_rx_byte
);

    tmruart_pkg::period_t              period_reg;
    tmruart_pkg::period_t              period_eff;
    logic                              in_valid_reg;
    logic                              in_rx_line_reg;
    logic                              in_tx_start_reg;
    logic [tmruart_pkg::DATA_BITS-1:0] in_tx_byte_reg;
    logic                              out_valid_reg;
    tmruart_pkg::tx_status_t           tx_status, tx_out_reg;
    tmruart_pkg::rx_status_t           rx_status, rx_out_reg;
    logic                              out_free;
    logic                              step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= tmruart_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    assign period_eff = (period_reg == '0) ? tmruart_pkg::COUNT_WIDTH'(1) : period_reg;

    // The result register frees up in the same cycle its transfer completes.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_rx_line_reg  <= s_rx_line;
            in_tx_start_reg <= s_tx_start;
            in_tx_byte_reg  <= s_tx_byte;
        end
    end

    tmruart_tx u_tx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .tx_start (in_tx_start_reg),
        .tx_byte  (in_tx_byte_reg),
        .period   (period_eff),
        .status   (tx_status)
    );

    tmruart_rx u_rx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .rx_line  (in_rx_line_reg),
        .period   (period_eff),
        .status   (rx_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            tx_out_reg <= tx_status;
            rx_out_reg <= rx_status;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_tx_line  = tx_out_reg.tx_line;
    assign m_tx_busy  = tx_out_reg.tx_busy;
    assign m_tx_done  = tx_out_reg.tx_done;
    assign m_rx_valid = rx_out_reg.rx_valid;
    assign m_rx_byte  = rx_out_reg.rx_byte;

endmodule
